[hw/rtl/gaussian_kernel_evaluator_core_macros.svh]
// Assertion macros shared by the Gaussian kernel evaluator RTL.
`ifndef GAUSSIAN_KERNEL_EVALUATOR_CORE_MACROS_SVH
`define GAUSSIAN_KERNEL_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GKE_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gke assertion failed");
`define GKE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gke assertion failed");
`else
`define GKE_ASSERT_IMPLIES(label, ante, cons)
`define GKE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/gke_pkg.sv]
`timescale 1ns / 1ps
package gke_pkg;

   localparam int COORD_BITS  = 16;
   localparam int CENTER_BITS = 16;
   localparam int DIFF_BITS   = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 1;
   localparam int MAG_BITS    = 15;
   localparam int SQ_BITS     = 2 * MAG_BITS;
   localparam int TERM_BITS   = 30;
   localparam int SUM_BITS    = TERM_BITS + 2;
   localparam int AXES        = 4;
   localparam int DATA_BITS   = 32;

   localparam logic [TERM_BITS-1:0] EXP_CAP_Q24 = 30'h2000_0000;

   localparam int          Y_BITS    = 31;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

   localparam int EXP_TABLE_ENTRIES = 64;
   localparam int TABLE_BITS        = $clog2(EXP_TABLE_ENTRIES);
   localparam int REM_BITS          = 24 - TABLE_BITS;
   localparam int A_BITS            = 32 - TABLE_BITS;
   localparam int FRAC_BITS         = 31;
   localparam int MANT_BITS         = 31;
   localparam int P_BITS            = 33;
   localparam int SHIFT_BITS        = 6;
   localparam int N_BITS            = Y_BITS - 24;

   localparam logic [N_BITS-1:0] UNDERFLOW_N = 7'd34;

   localparam int STG_MAG    = 0;
   localparam int STG_SQ     = 1;
   localparam int STG_TERM   = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_Y      = 4;
   localparam int STG_POLY   = 5;
   localparam int STG_CORR   = 6;
   localparam int STG_MANT   = 7;
   localparam int STG_SCALE  = 8;
   localparam int STG_OUT    = 9;
   localparam int NUM_STAGES = 10;

   typedef enum logic [2:0] {
      CSR_AXIS_COUNT,
      CSR_NORM_FACTOR,
      CSR_WEIGHT_X,
      CSR_WEIGHT_Y,
      CSR_WEIGHT_Z,
      CSR_WEIGHT_T,
      CSR_CENTER_XY,
      CSR_CENTER_ZT
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic signed [COORD_BITS-1:0] coord_t;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] kernel_value;
      logic                 saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]                             axis_count;
      logic [DATA_BITS-1:0]                   norm_factor;
      logic [AXES-1:0][DATA_BITS-1:0]         weight;
      logic [AXES-1:0][CENTER_BITS-1:0]       center;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      axis_count:  3'd1,
      norm_factor: 32'd6693092,
      weight:      {AXES{32'd32768}},
      center:      '0
   };

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef logic [EXP_TABLE_ENTRIES-1:0][FRAC_BITS-1:0] frac_table_type;

   // Entry k holds 2^(-k/N) in Q.30, evaluated from a series through the t^20 term in Q.32.
   function automatic frac_table_type build_frac_table();
      frac_table_type tbl;
      logic [63:0]    t;
      logic [63:0]    term;
      logic [63:0]    pos;
      logic [63:0]    neg;
      for (int unsigned k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         t    = (64'(k) * 64'(LN2_Q32)) / EXP_TABLE_ENTRIES;
         term = 64'd1 << 32;
         pos  = term;
         neg  = '0;
         for (int unsigned i = 1; i <= 20; i++) begin
            term = ((term * t) >> 32) / 64'(i);
            if (i[0]) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         tbl[k] = FRAC_BITS'(((pos - neg) + 64'd2) >> 2);
      end
      return tbl;
   endfunction

   localparam frac_table_type FRAC_TABLE = build_frac_table();

endpackage

[hw/rtl/gke_lane.sv]
`timescale 1ns / 1ps
module gke_lane import gke_pkg::*; (
   input  logic                         clock,
   input  pipe_ctrl_type                ctrl,
   input  logic signed [COORD_BITS-1:0] coord,
   input  logic [CENTER_BITS-1:0]       center,
   input  logic [DATA_BITS-1:0]         weight,
   output logic [TERM_BITS-1:0]         term
);

   logic signed [DIFF_BITS-1:0]         diff;
   logic [DIFF_BITS-1:0]                mag;
   logic [MAG_BITS-1:0]                 mag_in;
   logic [MAG_BITS-1:0]                 mag_ff;
   logic                                big_in;
   logic                                big_ff;
   logic [SQ_BITS-1:0]                  sq_in;
   logic [SQ_BITS-1:0]                  sq_ff;
   logic                                big_sq_ff;
   logic [SQ_BITS+TERM_BITS-1:0]        prod;
   logic                                w_hi;
   logic [TERM_BITS-1:0]                term_in;
   logic [TERM_BITS-1:0]                term_ff;

   always_comb begin
      diff   = DIFF_BITS'(coord) - DIFF_BITS'($signed(center));
      mag    = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      mag_in = mag[MAG_BITS-1:0];
      big_in = |mag[DIFF_BITS-1:MAG_BITS];
   end

   assign sq_in = SQ_BITS'(mag_ff) * SQ_BITS'(mag_ff);

   // An offset of 2^15 lsb or more squares to at least 2^30, which exceeds the cap
   // for any nonzero weight, as does any weight of 2^30 or more.
   always_comb begin
      w_hi = |weight[DATA_BITS-1:TERM_BITS];
      prod = (SQ_BITS+TERM_BITS)'(sq_ff) * (SQ_BITS+TERM_BITS)'(weight[TERM_BITS-1:0]);
      if ((weight == '0) || ((sq_ff == '0) && !big_sq_ff)) begin
         term_in = '0;
      end else if (big_sq_ff || w_hi) begin
         term_in = EXP_CAP_Q24;
      end else if (prod > (SQ_BITS+TERM_BITS)'(EXP_CAP_Q24)) begin
         term_in = EXP_CAP_Q24;
      end else begin
         term_in = prod[TERM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_MAG]) begin
         mag_ff <= mag_in;
         big_ff <= big_in;
      end
      if (ctrl.load[STG_SQ]) begin
         sq_ff     <= sq_in;
         big_sq_ff <= big_ff;
      end
      if (ctrl.load[STG_TERM]) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

[hw/rtl/gke_merge.sv]
`timescale 1ns / 1ps
module gke_merge import gke_pkg::*; (
   input  logic                             clock,
   input  pipe_ctrl_type                    ctrl,
   input  logic [2:0]                       axis_count,
   input  logic [AXES-1:0][TERM_BITS-1:0]   terms,
   output logic [TERM_BITS-1:0]             expo
);

   logic [2:0]           axes_eff;
   logic [SUM_BITS-1:0]  sum;
   logic [TERM_BITS-1:0] expo_in;
   logic [TERM_BITS-1:0] expo_ff;

   always_comb begin
      if (axis_count == 3'd0) begin
         axes_eff = 3'd1;
      end else if (axis_count > 3'(AXES)) begin
         axes_eff = 3'(AXES);
      end else begin
         axes_eff = axis_count;
      end
      sum = '0;
      for (int i = 0; i < AXES; i++) begin
         if (3'(i) < axes_eff) begin
            sum = sum + SUM_BITS'(terms[i]);
         end
      end
      expo_in = (sum > SUM_BITS'(EXP_CAP_Q24)) ? EXP_CAP_Q24 : sum[TERM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_SUM]) begin
         expo_ff <= expo_in;
      end
   end

   assign expo = expo_ff;

endmodule

[hw/rtl/gke_exp.sv]
`timescale 1ns / 1ps
module gke_exp import gke_pkg::*; (
   input  logic                  clock,
   input  pipe_ctrl_type         ctrl,
   input  logic [TERM_BITS-1:0]  expo,
   input  logic [DATA_BITS-1:0]  norm_factor,
   output rsp_payload_type       result
);

   logic [TERM_BITS+30:0]         y_prod;
   logic [Y_BITS-1:0]             y_in;
   logic [Y_BITS-1:0]             y_ff;

   logic [N_BITS-1:0]             n_full;
   logic [REM_BITS+31:0]          a_prod;
   logic [A_BITS-1:0]             a_in;
   logic [A_BITS-1:0]             a_ff;
   logic [TABLE_BITS-1:0]         k_ff;
   logic [SHIFT_BITS-1:0]         shift_poly_ff;
   logic                          under_poly_ff;

   logic [2*A_BITS-1:0]           a_sq;
   logic [P_BITS-1:0]             p_in;
   logic [P_BITS-1:0]             p_ff;
   logic [FRAC_BITS-1:0]          frac_ff;
   logic [SHIFT_BITS-1:0]         shift_corr_ff;
   logic                          under_corr_ff;

   logic [FRAC_BITS+31:0]         m_prod;
   logic [MANT_BITS-1:0]          mant_in;
   logic [MANT_BITS-1:0]          mant_ff;
   logic [SHIFT_BITS-1:0]         shift_mant_ff;
   logic                          under_mant_ff;

   logic [DATA_BITS+MANT_BITS-1:0] s_prod_in;
   logic [DATA_BITS+MANT_BITS-1:0] s_prod_ff;
   logic [SHIFT_BITS-1:0]         shift_scale_ff;
   logic                          under_scale_ff;

   logic [N_BITS-1:0]             shift_total;
   logic [63:0]                   rounded;
   logic [63:0]                   val;
   rsp_payload_type               result_in;
   rsp_payload_type               result_ff;

   always_comb begin
      y_prod = (TERM_BITS+31)'(expo) * (TERM_BITS+31)'(LOG2E_Q30);
      y_in   = Y_BITS'((y_prod + ((TERM_BITS+31)'(1) << 29)) >> 30);
   end

   always_comb begin
      n_full = y_ff[Y_BITS-1:24];
      a_prod = (REM_BITS+32)'(y_ff[REM_BITS-1:0]) * (REM_BITS+32)'(LN2_Q32);
      a_in   = A_BITS'(a_prod >> 24);
   end

   always_comb begin
      a_sq = (2*A_BITS)'(a_ff) * (2*A_BITS)'(a_ff);
      p_in = (P_BITS'(1) << 32) - P_BITS'(a_ff) + P_BITS'(a_sq >> 33);
   end

   always_comb begin
      if (p_ff[P_BITS-1]) begin
         m_prod = {frac_ff, 32'd0};
      end else begin
         m_prod = (FRAC_BITS+32)'(frac_ff) * (FRAC_BITS+32)'(p_ff[31:0]);
      end
      mant_in = MANT_BITS'((64'(m_prod) + 64'h8000_0000) >> 32);
   end

   assign s_prod_in = (DATA_BITS+MANT_BITS)'(norm_factor) * (DATA_BITS+MANT_BITS)'(mant_ff);

   always_comb begin
      shift_total = N_BITS'(30) + N_BITS'(shift_scale_ff);
      rounded     = (64'(s_prod_ff) + (64'd1 << (shift_total - N_BITS'(1)))) >> shift_total;
      val         = under_scale_ff ? 64'd0 : rounded;
      result_in.saturated    = (val > 64'hFFFF_FFFF);
      result_in.kernel_value = result_in.saturated ? '1 : val[DATA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_Y]) begin
         y_ff <= y_in;
      end
      if (ctrl.load[STG_POLY]) begin
         a_ff          <= a_in;
         k_ff          <= y_ff[23:24-TABLE_BITS];
         shift_poly_ff <= n_full[SHIFT_BITS-1:0];
         under_poly_ff <= (n_full >= UNDERFLOW_N);
      end
      if (ctrl.load[STG_CORR]) begin
         p_ff          <= p_in;
         frac_ff       <= FRAC_TABLE[k_ff];
         shift_corr_ff <= shift_poly_ff;
         under_corr_ff <= under_poly_ff;
      end
      if (ctrl.load[STG_MANT]) begin
         mant_ff       <= mant_in;
         shift_mant_ff <= shift_corr_ff;
         under_mant_ff <= under_corr_ff;
      end
      if (ctrl.load[STG_SCALE]) begin
         s_prod_ff      <= s_prod_in;
         shift_scale_ff <= shift_mant_ff;
         under_scale_ff <= under_mant_ff;
      end
      if (ctrl.load[STG_OUT]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[hw/rtl/gaussian_kernel_evaluator_core.sv]
`timescale 1ns / 1ps
// Evaluates a normalized axis-aligned Gaussian at one 1D to 4D point per clock
// while results are taken. The core is a ten-stage pipeline: four lanes form the
// weighted squared offsets of x, y, z and t, a merging stage sums the active axes,
// and a shared exponent unit does the power-of-two reduction, fraction table
// lookup, polynomial correction and normalization. A point moves through the
// lane, merge and exponent stages in order, and rsp_valid is the valid of the last
// stage. One new point can be taken every cycle as long as results are taken.
// An input skid register keeps req_stall a registered signal, so it never
// follows rsp_stall in the same cycle. The register port is always ready;
// registers should be written only while no point is in flight.
`include "gaussian_kernel_evaluator_core_macros.svh"
module gaussian_kernel_evaluator_core import gke_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  csr_index_type        csr_index,
   input  logic [DATA_BITS-1:0] csr_wdata
);

   cfg_type                           cfg_in;
   cfg_type                           cfg_ff;

   logic                              skid_valid_in;
   logic                              skid_valid_ff;
   req_payload_type                   skid_data_in;
   req_payload_type                   skid_data_ff;
   logic                              req_accept;
   logic                              src_valid;
   req_payload_type                   src_data;
   logic                              pipe_ready;

   logic [NUM_STAGES-1:0]             valid_in;
   logic [NUM_STAGES-1:0]             valid_ff;
   logic [NUM_STAGES-1:0]             ready;
   logic [NUM_STAGES-1:0]             stage_src_valid;
   pipe_ctrl_type                     ctrl;

   logic signed [COORD_BITS-1:0]      lane_coord [AXES];
   logic [AXES-1:0][TERM_BITS-1:0]    lane_term;
   logic [TERM_BITS-1:0]              expo;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_AXIS_COUNT:  cfg_in.axis_count  = csr_wdata[2:0];
            CSR_NORM_FACTOR: cfg_in.norm_factor = csr_wdata;
            CSR_WEIGHT_X:    cfg_in.weight[0]   = csr_wdata;
            CSR_WEIGHT_Y:    cfg_in.weight[1]   = csr_wdata;
            CSR_WEIGHT_Z:    cfg_in.weight[2]   = csr_wdata;
            CSR_WEIGHT_T:    cfg_in.weight[3]   = csr_wdata;
            CSR_CENTER_XY:   cfg_in.center[1:0] = csr_wdata;
            CSR_CENTER_ZT:   cfg_in.center[3:2] = csr_wdata;
         endcase
      end
   end

   always_comb begin
      req_stall     = skid_valid_ff;
      req_accept    = req_valid && !skid_valid_ff;
      src_valid     = skid_valid_ff || req_valid;
      src_data      = skid_valid_ff ? skid_data_ff : req_payload;
      skid_valid_in = skid_valid_ff ? !pipe_ready : (req_accept && !pipe_ready);
      skid_data_in  = skid_valid_ff ? skid_data_ff : req_payload;
   end

   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      stage_src_valid = {valid_ff[NUM_STAGES-2:0], src_valid};
      for (int i = 0; i < NUM_STAGES; i++) begin
         valid_in[i]      = ready[i] ? stage_src_valid[i] : valid_ff[i];
         ctrl.load[i]     = ready[i] && stage_src_valid[i];
      end
      pipe_ready = ready[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         skid_valid_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         skid_valid_ff <= skid_valid_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_data_ff <= skid_data_in;
   end

   always_comb begin
      lane_coord[0] = src_data.coord_x;
      lane_coord[1] = src_data.coord_y;
      lane_coord[2] = src_data.coord_z;
      lane_coord[3] = src_data.coord_t;
   end

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      gke_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .coord  (lane_coord[g]),
         .center (cfg_ff.center[g]),
         .weight (cfg_ff.weight[g]),
         .term   (lane_term[g])
      );
   end

   gke_merge u_merge (
      .clock      (clock),
      .ctrl       (ctrl),
      .axis_count (cfg_ff.axis_count),
      .terms      (lane_term),
      .expo       (expo)
   );

   gke_exp u_exp (
      .clock       (clock),
      .ctrl        (ctrl),
      .expo        (expo),
      .norm_factor (cfg_ff.norm_factor),
      .result      (rsp_payload)
   );

   assign rsp_valid = valid_ff[NUM_STAGES-1];

   `GKE_ASSERT_IMPLIES(a_sat_full_scale, rsp_valid && rsp_payload.saturated, rsp_payload.kernel_value == '1)
   `GKE_ASSERT_NEXT(a_skid_capture, req_valid && !req_stall && !pipe_ready, skid_valid_ff)
   `GKE_ASSERT_NEXT(a_no_item_lost, valid_ff[STG_SCALE] && !ready[STG_OUT], valid_ff[STG_SCALE])

endmodule

[sim/gaussian_kernel_evaluator_core_tb.sv]
`timescale 1ns / 1ps
module gaussian_kernel_evaluator_core_tb;
   import gke_pkg::*;

   localparam longint unsigned LN_2_Q32       = 64'd2977044472;
   localparam longint unsigned LOG2_E_Q30     = 64'd1549082005;
   localparam longint unsigned EXPONENT_CAP   = 64'd1 << 29;
   localparam longint unsigned OFFSET_LIMIT   = 64'd2147483647;
   localparam longint unsigned UNDERFLOW_STEP = 64'd34;
   localparam int unsigned     MAX_REPORTS    = 10;

   typedef struct packed {
      logic [2:0]        axis_count;
      logic [31:0]       norm_factor;
      logic [3:0][31:0]  weight;
      logic [3:0][15:0]  center;
   } kernel_setup_t;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [DATA_BITS-1:0] csr_wdata;

   kernel_setup_t        kernel_setup;
   longint unsigned      pow2_frac [EXP_TABLE_ENTRIES];
   rsp_payload_type      pending_kernels [$];
   int unsigned          mismatch_count;
   int unsigned          burst_left;
   logic                 stream_mode;
   int unsigned          hold_off_request;

   gaussian_kernel_evaluator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic void build_pow2_fraction_table();
      longint unsigned t;
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      for (int unsigned k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         t    = (64'(k) * LN_2_Q32) / EXP_TABLE_ENTRIES;
         term = 64'd1 << 32;
         pos  = term;
         neg  = 64'd0;
         for (int unsigned i = 1; i <= 20; i++) begin
            term = ((term * t) >> 32) / 64'(i);
            if (i % 2 == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         pow2_frac[k] = ((pos - neg) + 64'd2) >> 2;
      end
   endfunction

   function automatic longint unsigned weighted_square(logic signed [15:0] coord,
                                                       logic signed [15:0] ctr,
                                                       logic [31:0] w);
      longint          offset;
      longint unsigned mag;
      longint unsigned sq;
      offset = longint'(coord) - longint'(ctr);
      mag    = (offset < 0) ? longint'(-offset) : offset;
      if (mag > OFFSET_LIMIT) begin
         mag = OFFSET_LIMIT;
      end
      sq = mag * mag;
      if (w == 32'd0) begin
         return 64'd0;
      end
      if (sq > EXPONENT_CAP / 64'(w)) begin
         return EXPONENT_CAP;
      end
      return sq * 64'(w);
   endfunction

   function automatic longint unsigned pow2_neg_mantissa(longint unsigned frac);
      longint unsigned scaled;
      longint unsigned k;
      longint unsigned rem;
      longint unsigned a;
      longint unsigned p;
      scaled = frac * EXP_TABLE_ENTRIES;
      k      = scaled >> 24;
      rem    = scaled - (k << 24);
      a      = ((rem * LN_2_Q32) >> 24) / EXP_TABLE_ENTRIES;
      p      = (64'd1 << 32) - a + ((a * a) >> 33);
      if (k >= EXP_TABLE_ENTRIES) begin
         k = EXP_TABLE_ENTRIES - 1;
      end
      return (pow2_frac[k] * p + (64'd1 << 31)) >> 32;
   endfunction

   function automatic rsp_payload_type predict_kernel(req_payload_type pt);
      int unsigned     axes;
      longint unsigned e;
      longint unsigned y;
      longint unsigned n;
      longint unsigned prod;
      longint unsigned val;
      int unsigned     s;
      rsp_payload_type r;
      axes = kernel_setup.axis_count;
      if (axes < 1) begin
         axes = 1;
      end
      if (axes > 4) begin
         axes = 4;
      end
      e = weighted_square(pt.coord_x, kernel_setup.center[0], kernel_setup.weight[0]);
      if (axes >= 2) begin
         e += weighted_square(pt.coord_y, kernel_setup.center[1], kernel_setup.weight[1]);
      end
      if (axes >= 3) begin
         e += weighted_square(pt.coord_z, kernel_setup.center[2], kernel_setup.weight[2]);
      end
      if (axes >= 4) begin
         e += weighted_square(pt.coord_t, kernel_setup.center[3], kernel_setup.weight[3]);
      end
      if (e > EXPONENT_CAP) begin
         e = EXPONENT_CAP;
      end
      y = (e * LOG2_E_Q30 + (64'd1 << 29)) >> 30;
      n = y >> 24;
      if (n >= UNDERFLOW_STEP) begin
         val = 64'd0;
      end else begin
         prod = 64'(kernel_setup.norm_factor) * pow2_neg_mantissa(y & 64'hFF_FFFF);
         s    = 30 + int'(n);
         val  = (prod + (64'd1 << (s - 1))) >> s;
      end
      r.saturated = 1'b0;
      if (val > 64'hFFFF_FFFF) begin
         val         = 64'hFFFF_FFFF;
         r.saturated = 1'b1;
      end
      r.kernel_value = val[31:0];
      return r;
   endfunction

   function automatic req_payload_type make_point(logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] z, logic [15:0] t);
      req_payload_type pt;
      pt.coord_x = x;
      pt.coord_y = y;
      pt.coord_z = z;
      pt.coord_t = t;
      return pt;
   endfunction

   function automatic req_payload_type random_point();
      logic [3:0][15:0] c;
      logic [15:0]      off;
      if ($urandom_range(0, 9) < 3) begin
         return {$urandom, $urandom};
      end
      for (int a = 0; a < 4; a++) begin
         off = 16'($urandom_range(0, 1 << $urandom_range(0, 10)));
         if ($urandom_range(0, 1) == 1) begin
            off = -off;
         end
         c[a] = kernel_setup.center[a] + off;
      end
      return make_point(c[0], c[1], c[2], c[3]);
   endfunction

   function automatic kernel_setup_t random_setup();
      kernel_setup_t s;
      if ($urandom_range(0, 5) == 0) begin
         s.axis_count = 3'($urandom_range(0, 7));
      end else begin
         s.axis_count = 3'($urandom_range(1, 4));
      end
      case ($urandom_range(0, 3))
         0: s.norm_factor = $urandom;
         1: s.norm_factor = 32'hFFFF_FFFF;
         default: s.norm_factor = $urandom_range(32'h0010_0000, 32'h0400_0000);
      endcase
      for (int a = 0; a < 4; a++) begin
         case ($urandom_range(0, 7))
            0: s.weight[a] = 32'd0;
            1: s.weight[a] = 32'hFFFF_FFFF;
            2: s.weight[a] = $urandom;
            default: s.weight[a] = $urandom_range(32'h100, 32'h4_0000);
         endcase
         s.center[a] = 16'($urandom);
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_kernels.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, rsp_payload.kernel_value);
         end else begin
            want = pending_kernels.pop_front();
            if (rsp_payload.kernel_value !== want.kernel_value) begin
               report_mismatch("kernel_value", want.kernel_value, rsp_payload.kernel_value);
            end
            if (rsp_payload.saturated !== want.saturated) begin
               report_mismatch("saturated", 32'(want.saturated), 32'(rsp_payload.saturated));
            end
         end
      end
   end

   initial begin : rsp_stall_gen
      int unsigned mode_left;
      int unsigned mode;
      int unsigned hold_len;
      logic [15:0] pattern;
      mode_left = 0;
      mode      = 0;
      pattern   = 16'h0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request != 0) begin
            hold_len         = hold_off_request;
            hold_off_request = 0;
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 80);
               pattern   = 16'($urandom);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: begin
                  rsp_stall <= pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // The valid stays high after a transfer so that back-to-back points need no gap;
   // send_point lowers it for random gaps outside stream mode, and drain_points lowers it.
   task automatic send_point(input req_payload_type pt);
      int unsigned gap;
      if (!stream_mode) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid   <= 1'b1;
      req_payload <= pt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_kernels.push_back(predict_kernel(pt));
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      while (pending_kernels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_transfer(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_config(input kernel_setup_t s);
      drain_points();
      csr_transfer(CSR_AXIS_COUNT, {29'($urandom), s.axis_count});
      csr_transfer(CSR_NORM_FACTOR, s.norm_factor);
      csr_transfer(CSR_WEIGHT_X, s.weight[0]);
      csr_transfer(CSR_WEIGHT_Y, s.weight[1]);
      csr_transfer(CSR_WEIGHT_Z, s.weight[2]);
      csr_transfer(CSR_WEIGHT_T, s.weight[3]);
      csr_transfer(CSR_CENTER_XY, {s.center[1], s.center[0]});
      csr_transfer(CSR_CENTER_ZT, {s.center[3], s.center[2]});
      csr_valid <= 1'b0;
      kernel_setup = s;
   endtask

   task automatic test_reset_defaults();
      send_point(make_point(16'h0000, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'h0010, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'hFFF0, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'h7FFF, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'h8000, 16'($urandom), 16'($urandom), 16'($urandom)));
      drain_points();
   endtask

   task automatic test_zero_weight();
      kernel_setup_t s;
      s.axis_count  = 3'd4;
      s.norm_factor = 32'hFFFF_FFFF;
      s.weight      = '0;
      s.center      = '0;
      apply_config(s);
      send_point({$urandom, $urandom});
      drain_points();
   endtask

   task automatic test_huge_offsets();
      kernel_setup_t s;
      s.axis_count  = 3'd4;
      s.norm_factor = 32'hFFFF_FFFF;
      s.weight      = {4{32'hFFFF_FFFF}};
      s.center      = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      apply_config(s);
      send_point(make_point(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_point(make_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
      send_point(make_point(16'h7FFE, 16'h8000, 16'h7FFF, 16'h8000));
      drain_points();
   endtask

   task automatic test_deep_underflow();
      kernel_setup_t s;
      s.axis_count  = 3'd1;
      s.norm_factor = 32'hFFFF_FFFF;
      s.weight      = {4{32'h0001_0000}};
      s.center      = '0;
      apply_config(s);
      send_point(make_point(16'd76, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'd77, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'd78, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(16'd79, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_point(make_point(-16'sd78, 16'($urandom), 16'($urandom), 16'($urandom)));
      drain_points();
   endtask

   task automatic test_axis_counts();
      kernel_setup_t s;
      logic [2:0]    counts [5];
      counts        = '{3'd0, 3'd2, 3'd3, 3'd5, 3'd7};
      s.norm_factor = 32'h0100_0000;
      s.weight      = {4{32'h0001_0000}};
      s.center      = '0;
      foreach (counts[i]) begin
         s.axis_count = counts[i];
         apply_config(s);
         send_point(make_point(16'h0010, 16'h0010, 16'h0010, 16'h0010));
      end
      drain_points();
   endtask

   task automatic test_random_kernels();
      kernel_setup_t s;
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            s.axis_count  = 3'd7;
            s.norm_factor = 32'hFFFF_FFFF;
            s.weight      = {4{32'hFFFF_FFFF}};
            s.center      = {4{16'hFFFF}};
         end else if (phase == 1) begin
            s = '0;
         end else begin
            s = random_setup();
         end
         apply_config(s);
         repeat (120) send_point(random_point());
      end
      drain_points();
   endtask

   task automatic test_backpressure();
      apply_config(random_setup());
      stream_mode      = 1'b1;
      hold_off_request = 64;
      repeat (100) send_point(random_point());
      stream_mode = 1'b0;
      repeat (100) send_point(random_point());
      drain_points();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_AXIS_COUNT;
      csr_wdata        = '0;
      mismatch_count   = 0;
      burst_left       = 0;
      stream_mode      = 1'b0;
      hold_off_request = 0;
      kernel_setup.axis_count  = 3'd1;
      kernel_setup.norm_factor = 32'd6693092;
      kernel_setup.weight      = {4{32'd32768}};
      kernel_setup.center      = '0;
      build_pow2_fraction_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_zero_weight();
      test_huge_offsets();
      test_deep_underflow();
      test_axis_counts();
      test_random_kernels();
      test_backpressure();

      drain_points();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_kernels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
